>>> hdl/lba_to_chs_translator_core_assert.svh
// Assertion macros for the LBA to CHS translator.
`ifndef LBA_TO_CHS_TRANSLATOR_CORE_ASSERT_SVH
`define LBA_TO_CHS_TRANSLATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define L2C_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define L2C_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define L2C_ASSERT(label, clk, rst_n, prop)
`define L2C_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> hdl/l2c_pkg.sv
package l2c_pkg;
  localparam int unsigned TrkW = 24;
  localparam logic [24:0] ChsLimit = 25'd16515072;
  localparam int unsigned SptW = 6;
  localparam int unsigned HdW = 9;
  localparam int unsigned CylCntW = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LIMIT = 2'd1,
    ST_GEOM  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SPT  = 2'd0,
    REG_HEAD = 2'd1,
    REG_CYL  = 2'd2
  } reg_idx_t;
endpackage

>>> hdl/l2c_if.sv
interface l2c_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] lba;
  modport source (output valid, lba, input ready);
  modport sink (input valid, lba, output ready);
endinterface

interface l2c_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [23:0] cylinder;
  logic [7:0]  head;
  logic [5:0]  track_sector;
  logic [15:0] packed_cx;
  modport source (output valid, status, cylinder, head, track_sector, packed_cx,
                  input ready);
  modport sink (input valid, status, cylinder, head, track_sector, packed_cx,
                output ready);
endinterface

interface l2c_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/l2c_div.sv
// Restoring divider: one quotient bit per stage, all stages advance on en.
module l2c_div #(
  parameter int unsigned NumW = 25,
  parameter int unsigned DenW = 9,
  parameter int unsigned TagW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NumW-1:0] in_num,
  input  logic [DenW-1:0] in_den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_valid,
  output logic [NumW-1:0] out_quo,
  output logic [DenW-1:0] out_rem,
  output logic [TagW-1:0] out_tag
);
  logic [NumW:1]   vld_r;
  logic [NumW-1:0] num_r [1:NumW];
  logic [DenW-1:0] rem_r [1:NumW];
  logic [DenW-1:0] den_r [1:NumW];
  logic [TagW-1:0] tag_r [1:NumW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NumW-1:1], in_valid};
    end
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [NumW-1:0] cur_num;
    logic [DenW-1:0] cur_rem;
    logic [DenW-1:0] cur_den;
    logic [TagW-1:0] cur_tag;
    logic [DenW+1:0] trial;
    logic [DenW:0]   shifted;
    if (s == 0) begin : g_first
      assign cur_num = in_num;
      assign cur_rem = '0;
      assign cur_den = in_den;
      assign cur_tag = in_tag;
    end else begin : g_next
      assign cur_num = num_r[s];
      assign cur_rem = rem_r[s];
      assign cur_den = den_r[s];
      assign cur_tag = tag_r[s];
    end
    always_comb begin
      shifted = {cur_rem, cur_num[NumW-1]};
      trial = {1'b0, shifted} - {2'b00, cur_den};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s+1] <= cur_den;
        tag_r[s+1] <= cur_tag;
        if (trial[DenW+1]) begin
          rem_r[s+1] <= shifted[DenW-1:0];
          num_r[s+1] <= {cur_num[NumW-2:0], 1'b0};
        end else begin
          rem_r[s+1] <= trial[DenW-1:0];
          num_r[s+1] <= {cur_num[NumW-2:0], 1'b1};
        end
      end
    end
  end

  assign out_valid = vld_r[NumW];
  assign out_quo   = num_r[NumW];
  assign out_rem   = rem_r[NumW];
  assign out_tag   = tag_r[NumW];
endmodule

>>> hdl/lba_to_chs_translator_core.sv
// LBA to CHS translator.
// in channel: one 64-bit LBA per transaction. out channel: status,
// cylinder, head, track_sector and packed CX word per transaction.
// cfg channel: index 0 sectors per track, 1 head count, 2 cylinder count;
// always ready; the user must write it only while the block is idle; the
// block does not enforce this. Pipeline: 51 register stages (one range
// check stage, 25 stages of the sector divider, 24 of the head divider,
// output stage).
// Throughput: one transaction per cycle while the receiver does not stall;
// each divider stage yields one quotient bit.
// Reset clears all valid bits and loads geometry 63 sectors, 255 heads,
// 1024 cylinders. When the receiver stalls the whole pipeline holds; input
// ready is high whenever the output register is empty or being taken.
module lba_to_chs_translator_core (
  input logic  clk,
  input logic  rst_n,
  l2c_in_if.sink    in_ch,
  l2c_out_if.source out_ch,
  l2c_cfg_if.sink   cfg_ch
);
  import l2c_pkg::*;
  `include "lba_to_chs_translator_core_assert.svh"

  logic [SptW-1:0]    spt_r;
  logic [HdW-1:0]     heads_r;
  logic [CylCntW-1:0] cyl_cnt_r;
  logic [SptW-1:0]    spt_eff;
  logic [HdW-1:0]     heads_eff;
  logic en;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r     <= 6'd63;
      heads_r   <= 9'd255;
      cyl_cnt_r <= 16'd1024;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_SPT:  spt_r     <= cfg_ch.data[SptW-1:0];
        REG_HEAD: heads_r   <= cfg_ch.data[HdW-1:0];
        REG_CYL:  cyl_cnt_r <= cfg_ch.data[CylCntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    spt_eff = (spt_r == '0) ? 6'd63 : spt_r;
    if (heads_r == '0) heads_eff = 9'd255;
    else if (heads_r > 9'd256) heads_eff = 9'd256;
    else heads_eff = heads_r;
  end

  logic out_valid_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 0: range check
  logic        s0_valid_r;
  logic        s0_over_r;
  logic [24:0] s0_lba_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else if (en) s0_valid_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_over_r <= (in_ch.lba[63:25] != '0) || (in_ch.lba[24:0] > ChsLimit);
      s0_lba_r  <= in_ch.lba[24:0];
    end
  end

  logic            d1_valid;
  logic [24:0]     d1_quo;
  logic [SptW-1:0] d1_rem;
  logic            d1_over;
  l2c_div #(.NumW(25), .DenW(SptW), .TagW(1)) u_div_spt (
    .clk, .rst_n, .en,
    .in_valid(s0_valid_r), .in_num(s0_over_r ? 25'd0 : s0_lba_r),
    .in_den(spt_eff), .in_tag(s0_over_r),
    .out_valid(d1_valid), .out_quo(d1_quo), .out_rem(d1_rem), .out_tag(d1_over)
  );

  logic             d2_valid;
  logic [TrkW-1:0]  d2_quo;
  logic [HdW-1:0]   d2_rem;
  logic [SptW:0]    d2_tag;
  l2c_div #(.NumW(TrkW), .DenW(HdW), .TagW(SptW+1)) u_div_head (
    .clk, .rst_n, .en,
    .in_valid(d1_valid), .in_num(d1_quo[TrkW-1:0]),
    .in_den(heads_eff), .in_tag({d1_over, d1_rem}),
    .out_valid(d2_valid), .out_quo(d2_quo), .out_rem(d2_rem), .out_tag(d2_tag)
  );

  logic [5:0]  sec;
  logic [23:0] cyl;
  assign sec = d2_tag[SptW-1:0] + 6'd1;
  assign cyl = d2_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= d2_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (d2_tag[SptW]) begin
        out_ch.status       <= ST_LIMIT;
        out_ch.cylinder     <= '0;
        out_ch.head         <= '0;
        out_ch.track_sector <= '0;
        out_ch.packed_cx    <= '0;
      end else begin
        out_ch.status       <= (cyl[15:0] >= cyl_cnt_r || cyl[23:16] != '0) ?
                               ST_GEOM : ST_OK;
        out_ch.cylinder     <= cyl;
        out_ch.head         <= d2_rem[7:0];
        out_ch.track_sector <= sec;
        out_ch.packed_cx    <= {cyl[7:0], cyl[9:8], sec};
      end
    end
  end
  assign out_ch.valid = out_valid_r;

  `L2C_ASSERT(a_hold, clk, rst_n, out_valid_r && !out_ch.ready |=> out_valid_r)
  `L2C_ASSERT(a_ready, clk, rst_n, !out_valid_r |-> in_ch.ready)
  `L2C_ASSERT(a_sec, clk, rst_n, out_valid_r && out_ch.status != ST_LIMIT |-> |out_ch.track_sector)
  `L2C_ASSERT_RST(a_rst, clk, !rst_n |=> !out_valid_r)
endmodule
